[rtl/bma_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// bma_pkg
// Shared types and constants of the broadcast matrix arithmetic block.
// ============================================================================
package bma_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed widths that follow from the interface fields.
    localparam int DATA_W = 32;
    localparam int DIM_W  = 4;   // dimension registers are four bits wide
    localparam int SZ_W   = 8;   // one operand holds at most 15 x 15 elements
    localparam int CNT_W  = 9;   // both operands together
    localparam int ACC_W  = 68;  // up to 15 exact 64-bit products

    // Depth of the job queue between front and back.
    localparam int JOB_Q_DEPTH = 2;

    // Operation codes.
    localparam logic [2:0] OP_MATMUL = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SUB    = 3'd2;
    localparam logic [2:0] OP_EMUL   = 3'd3;
    localparam logic [2:0] OP_EDIV   = 3'd4;

    // Result status codes.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_SHAPE   = 2'd1;
    localparam logic [1:0] STAT_DIVZERO = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_OPERATION = 3'd0;
    localparam logic [2:0] REG_A_ROWS    = 3'd1;
    localparam logic [2:0] REG_A_COLS    = 3'd2;
    localparam logic [2:0] REG_B_ROWS    = 3'd3;
    localparam logic [2:0] REG_B_COLS    = 3'd4;

    // One complete run, as classified by the front.
    typedef struct packed {
        logic [2:0]       op;
        logic [DIM_W-1:0] ar;
        logic [DIM_W-1:0] ac;
        logic [DIM_W-1:0] br;
        logic [DIM_W-1:0] bc;
        logic [SZ_W-1:0]  bsz;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic             product;
        logic [1:0]       status;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

[rtl/broadcast_matrix_arithmetic.sv]
`timescale 1ns / 1ps
// ============================================================================
// broadcast_matrix_arithmetic
// Matrix product and broadcast elementwise arithmetic on signed Q16.16 data.
// ============================================================================
// Operand elements arrive one request per cycle on the input channel: first
// all of A, then all of B, both in row-major order, with the shapes and the
// operation taken from the configuration registers (a dimension of zero
// counts as one, one above MAX_DIM counts as MAX_DIM). Loading runs at one
// element per cycle while in_stall is low. When the last element of B is
// taken, the front hands a classified run to the back through a short job
// queue, and the input is stalled until the back has emitted the last result
// of that run. The back emits C in row-major order, one result request per
// element, with last set on the final one. Each result of a matrix product
// takes one read, one multiply and one accumulate per inner term, paced by
// the single shared multiplier; add, subtract and elementwise multiply take
// one read, one multiply and one accumulate; elementwise divide adds a
// restoring divider that retires one quotient bit per cycle, and a divide
// run first checks each element of B for zero with a read and a check. A bad
// shape, an unknown operation or a zero in B yields one result with value,
// row and col zero, last set and a nonzero status. Products and dot products
// are kept exact, rounded to nearest with ties upward and saturated; add and
// subtract saturate; divide truncates toward zero and saturates. The result
// register decouples the output, so a stalled result does not stop the
// computation of the next one until it is needed. Configuration is written
// through a separate channel that is always ready.
// ============================================================================
module broadcast_matrix_arithmetic import bma_pkg::*; #(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [DIM_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DATA_W-1:0] element,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] result_value,
    output logic [2:0]        result_row,
    output logic [2:0]        result_col,
    output logic [1:0]        status,
    output logic              last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    // Front to queue.
    logic              q_push;
    job_t              push_job;
    fifo_stat_t        q_stat;
    // Queue to back.
    logic              q_pop;
    logic              q_valid;
    job_t              head_job;
    logic              back_busy;
    // Operand memory ports.
    logic              a_we, b_we;
    logic [ADDR_W-1:0] wr_addr, a_raddr, b_raddr;
    logic [DATA_W-1:0] wr_data, a_rdata, b_rdata;

    bma_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .element   (element),
        .back_busy (back_busy),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_job     (push_job),
        .a_we      (a_we),
        .b_we      (b_we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // A and B stores share the write address; only one is enabled.
    bma_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    bma_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    bma_job_fifo u_job_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (push_job),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job),
        .stat       (q_stat)
    );

    bma_back #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_job        (head_job),
        .q_pop        (q_pop),
        .a_raddr      (a_raddr),
        .b_raddr      (b_raddr),
        .a_rdata      (a_rdata),
        .b_rdata      (b_rdata),
        .busy         (back_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .result_row   (result_row),
        .result_col   (result_col),
        .status       (status),
        .last         (last)
    );

endmodule

[rtl/bma_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// bma_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module bma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/bma_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// bma_front
// Configuration registers, operand loading and shape classification.
// ============================================================================
module bma_front import bma_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [2:0]                       cfg_index,
    input  logic [DIM_W-1:0]                 cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [DATA_W-1:0]                element,
    input  logic                             back_busy,
    input  fifo_stat_t                       q_stat,
    output logic                             q_push,
    output job_t                             q_job,
    output logic                             a_we,
    output logic                             b_we,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr,
    output logic [DATA_W-1:0]                wr_data
);

    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

    logic [2:0]       op_reg;
    logic [DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [CNT_W-1:0] load_count_reg, load_count_next;

    logic [DIM_W-1:0] ar, ac, br, bc;
    logic [SZ_W-1:0]  asz, bsz;
    logic [CNT_W-1:0] total, b_idx, load_inc;
    logic             accept, a_sc, b_sc, shape_ok;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (32'(v) > MAX_DIM)
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    // Nothing is loaded while a run is queued or being computed.
    assign in_stall = back_busy || !q_stat.empty;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        ar       = eff_dim(a_rows_reg);
        ac       = eff_dim(a_cols_reg);
        br       = eff_dim(b_rows_reg);
        bc       = eff_dim(b_cols_reg);
        asz      = SZ_W'(ar) * SZ_W'(ac);
        bsz      = SZ_W'(br) * SZ_W'(bc);
        total    = CNT_W'(asz) + CNT_W'(bsz);
        b_idx    = load_count_reg - CNT_W'(asz);
        load_inc = load_count_reg + CNT_W'(1);
        a_sc     = (asz == SZ_W'(1));
        b_sc     = (bsz == SZ_W'(1));

        a_we    = 1'b0;
        b_we    = 1'b0;
        wr_addr = ADDR_W'(load_count_reg);
        wr_data = element;
        if (load_count_reg < CNT_W'(asz))
        begin
            a_we = accept;
        end
        else
        begin
            wr_addr = ADDR_W'(b_idx);
            b_we    = accept && (b_idx < CNT_W'(bsz));
        end

        q_push          = 1'b0;
        load_count_next = load_count_reg;
        if (accept)
        begin
            if (load_inc >= total)
            begin
                q_push          = 1'b1;
                load_count_next = '0;
            end
            else
            begin
                load_count_next = load_inc;
            end
        end

        shape_ok = ((op_reg inside {OP_MATMUL, OP_ADD, OP_SUB}) && (a_sc || b_sc))
                || (ar == br && ac == bc)
                || (ac == bc && (ar == DIM_W'(1) || br == DIM_W'(1)))
                || (ar == br && (ac == DIM_W'(1) || bc == DIM_W'(1)));

        q_job         = '0;
        q_job.op      = op_reg;
        q_job.ar      = ar;
        q_job.ac      = ac;
        q_job.br      = br;
        q_job.bc      = bc;
        q_job.bsz     = bsz;
        q_job.rows    = (ar > br) ? ar : br;
        q_job.cols    = (ac > bc) ? ac : bc;
        q_job.product = 1'b0;
        q_job.status  = STAT_OK;
        if (op_reg > OP_EDIV)
        begin
            q_job.status = STAT_SHAPE;
        end
        else if (op_reg == OP_MATMUL && !a_sc && !b_sc)
        begin
            if (ac != br)
            begin
                q_job.status = STAT_SHAPE;
            end
            else
            begin
                q_job.rows    = ar;
                q_job.cols    = bc;
                q_job.product = 1'b1;
            end
        end
        else if (!shape_ok)
        begin
            q_job.status = STAT_SHAPE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= OP_MATMUL;
            a_rows_reg     <= DIM_W'(1);
            a_cols_reg     <= DIM_W'(1);
            b_rows_reg     <= DIM_W'(1);
            b_cols_reg     <= DIM_W'(1);
            load_count_reg <= '0;
        end
        else
        begin
            load_count_reg <= load_count_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OPERATION: op_reg     <= cfg_data[2:0];
                    REG_A_ROWS:    a_rows_reg <= cfg_data;
                    REG_A_COLS:    a_cols_reg <= cfg_data;
                    REG_B_ROWS:    b_rows_reg <= cfg_data;
                    REG_B_COLS:    b_cols_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

endmodule

[rtl/bma_job_fifo.sv]
`timescale 1ns / 1ps
// ============================================================================
// bma_job_fifo
// Short queue of classified runs between the front and the back.
// ============================================================================
module bma_job_fifo import bma_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  job_t       push_job,
    input  logic       pop,
    output logic       head_valid,
    output job_t       head_job,
    output fifo_stat_t stat
);

    localparam int DEPTH = JOB_Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (32'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
    endfunction

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (32'(count_reg) == DEPTH);
    assign head_valid = !stat.empty;
    assign head_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !stat.full)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop && head_valid)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if ((push && !stat.full) && !(pop && head_valid))
            begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end
            else if (!(push && !stat.full) && (pop && head_valid))
            begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !stat.full)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/bma_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// bma_back
// Sequencer and datapath that compute and emit the elements of C.
// ============================================================================
module bma_back import bma_pkg::*; #(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  job_t                               q_job,
    output logic                               q_pop,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] a_raddr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] b_raddr,
    input  logic [DATA_W-1:0]                  a_rdata,
    input  logic [DATA_W-1:0]                  b_rdata,
    output logic                               busy,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [DATA_W-1:0]                  result_value,
    output logic [2:0]                         result_row,
    output logic [2:0]                         result_col,
    output logic [1:0]                         status,
    output logic                               last
);

    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int NUM_W  = DATA_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(NUM_W + 1);
    localparam logic signed [ACC_W-1:0] RND = ACC_W'((64'd1 << FRAC_BITS) >> 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN_RD  = 8'b0000_0010,
        S_SCAN_CHK = 8'b0000_0100,
        S_RD       = 8'b0000_1000,
        S_MUL      = 8'b0001_0000,
        S_ACC      = 8'b0010_0000,
        S_DIV      = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    state_t                    state_reg, state_next;
    job_t                      job_reg, job_next;
    logic [DIM_W-1:0]          i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [SZ_W-1:0]           scan_reg, scan_next;
    logic                      err_reg, err_next;
    logic [1:0]                stat_reg, stat_next;
    logic [DATA_W-1:0]         x_reg, x_next, y_reg, y_next;
    logic signed [63:0]        prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [DATA_W-1:0]         rem_reg, rem_next, den_reg, den_next;
    logic                      neg_reg, neg_next;
    logic [DCNT_W-1:0]         dcnt_reg, dcnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]         value_reg, value_next;
    logic [2:0]                row_reg, row_next, col_reg, col_next;
    logic [1:0]                ostat_reg, ostat_next;
    logic                      last_reg, last_next;

    logic [DIM_W-1:0]          a_r, a_c, b_r, b_c;
    logic [SZ_W-1:0]           a_idx, b_idx;
    logic                      out_free, is_last, ge;
    logic [DATA_W:0]           rem_sh;
    logic signed [ACC_W-1:0]   rnd_sum, shifted;
    logic signed [DATA_W:0]    as_sum;
    logic [DATA_W-1:0]         mac_val, as_val, div_val, xabs, yabs, value_calc;

    assign busy         = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_value = value_reg;
    assign result_row   = row_reg;
    assign result_col   = col_reg;
    assign status       = ostat_reg;
    assign last         = last_reg;
    assign out_free     = !out_valid_reg || !out_stall;

    // Operand addresses: the inner index k walks the dot product, and a
    // dimension of one pins that index of a broadcast operand to zero.
    always_comb
    begin
        if (job_reg.product)
        begin
            a_r = i_reg;
            a_c = k_reg;
            b_r = k_reg;
            b_c = j_reg;
        end
        else
        begin
            a_r = (job_reg.ar == DIM_W'(1)) ? '0 : i_reg;
            a_c = (job_reg.ac == DIM_W'(1)) ? '0 : j_reg;
            b_r = (job_reg.br == DIM_W'(1)) ? '0 : i_reg;
            b_c = (job_reg.bc == DIM_W'(1)) ? '0 : j_reg;
        end
        a_idx   = SZ_W'(a_r) * SZ_W'(job_reg.ac) + SZ_W'(a_c);
        b_idx   = SZ_W'(b_r) * SZ_W'(job_reg.bc) + SZ_W'(b_c);
        a_raddr = ADDR_W'(a_idx);
        b_raddr = (state_reg == S_SCAN_RD) ? ADDR_W'(scan_reg) : ADDR_W'(b_idx);
    end

    // Result arithmetic.
    always_comb
    begin
        rnd_sum = acc_reg + RND;
        shifted = rnd_sum >>> FRAC_BITS;
        if ((&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]))
        begin
            mac_val = shifted[DATA_W-1:0];
        end
        else
        begin
            mac_val = shifted[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end

        if (job_reg.op == OP_SUB)
        begin
            as_sum = $signed({x_reg[DATA_W-1], x_reg}) - $signed({y_reg[DATA_W-1], y_reg});
        end
        else
        begin
            as_sum = $signed({x_reg[DATA_W-1], x_reg}) + $signed({y_reg[DATA_W-1], y_reg});
        end
        if (as_sum[DATA_W] != as_sum[DATA_W-1])
        begin
            as_val = as_sum[DATA_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            as_val = as_sum[DATA_W-1:0];
        end

        if (!neg_reg)
        begin
            div_val = (num_reg > NUM_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                          : num_reg[DATA_W-1:0];
        end
        else
        begin
            div_val = (num_reg > NUM_W'(33'h0_8000_0000)) ? 32'h8000_0000
                                                          : DATA_W'(-num_reg);
        end

        if (job_reg.op inside {OP_ADD, OP_SUB})
        begin
            value_calc = as_val;
        end
        else if (job_reg.op == OP_EDIV)
        begin
            value_calc = div_val;
        end
        else
        begin
            value_calc = mac_val;
        end

        xabs   = x_reg[DATA_W-1] ? DATA_W'(-x_reg) : x_reg;
        yabs   = y_reg[DATA_W-1] ? DATA_W'(-y_reg) : y_reg;
        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        scan_next      = scan_reg;
        err_next       = err_reg;
        stat_next      = stat_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        dcnt_next      = dcnt_reg;
        value_next     = value_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        ostat_next     = ostat_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        is_last        = (i_reg == job_reg.rows - DIM_W'(1))
                      && (j_reg == job_reg.cols - DIM_W'(1));

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    job_next  = q_job;
                    i_next    = '0;
                    j_next    = '0;
                    k_next    = '0;
                    scan_next = '0;
                    acc_next  = '0;
                    err_next  = (q_job.status != STAT_OK);
                    stat_next = q_job.status;
                    if (q_job.status != STAT_OK)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (q_job.op == OP_EDIV)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (b_rdata == '0)
                begin
                    err_next   = 1'b1;
                    stat_next  = STAT_DIVZERO;
                    state_next = S_EMIT;
                end
                else if (scan_reg == job_reg.bsz - SZ_W'(1))
                begin
                    state_next = S_RD;
                end
                else
                begin
                    scan_next  = scan_reg + SZ_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_RD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                x_next     = a_rdata;
                y_next     = b_rdata;
                prod_next  = $signed(a_rdata) * $signed(b_rdata);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
                if (job_reg.op == OP_EDIV)
                begin
                    num_next   = NUM_W'(xabs) << FRAC_BITS;
                    den_next   = yabs;
                    rem_next   = '0;
                    neg_next   = x_reg[DATA_W-1] ^ y_reg[DATA_W-1];
                    dcnt_next  = DCNT_W'(NUM_W);
                    state_next = S_DIV;
                end
                else if (job_reg.product && (k_reg != job_reg.ac - DIM_W'(1)))
                begin
                    k_next     = k_reg + DIM_W'(1);
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_DIV:
            begin
                num_next  = {num_reg[NUM_W-2:0], ge};
                rem_next  = ge ? DATA_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DATA_W-1:0];
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = err_reg ? '0 : value_calc;
                    row_next       = err_reg ? '0 : i_reg[2:0];
                    col_next       = err_reg ? '0 : j_reg[2:0];
                    ostat_next     = stat_reg;
                    last_next      = err_reg || is_last;
                    if (err_reg || is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next   = '0;
                        acc_next = '0;
                        if (j_reg == job_reg.cols - DIM_W'(1))
                        begin
                            j_next = '0;
                            i_next = i_reg + DIM_W'(1);
                        end
                        else
                        begin
                            j_next = j_reg + DIM_W'(1);
                        end
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        scan_reg  <= scan_next;
        err_reg   <= err_next;
        stat_reg  <= stat_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        dcnt_reg  <= dcnt_next;
        value_reg <= value_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        ostat_reg <= ostat_next;
        last_reg  <= last_next;
    end

`ifndef NO_ASSERTIONS
    // An error run is a single zero result that closes the run.
    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ostat_reg != STAT_OK) |-> (last_reg && value_reg == '0))
        else $error("error result is not a closing zero");

    // The divide-by-zero scan keeps a zero divisor away from the divider.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC && job_reg.op == OP_EDIV) |-> (y_reg != '0))
        else $error("divider started with a zero divisor");

    // A dot product is emitted only after its last inner term.
    a_dot_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !err_reg && job_reg.product)
        |-> (k_reg == job_reg.ac - DIM_W'(1)))
        else $error("dot product emitted early");

    // The sequencer only leaves idle when it takes a queued run.
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !q_valid) |=> (state_reg == S_IDLE))
        else $error("sequencer started without a queued run");
`endif

endmodule
